// ===== hw/rtl/ssr_pkg.sv =====
`default_nettype none

package ssr_pkg;

    // Field widths
    localparam int unsigned ACCEL_W  = 11;
    localparam int unsigned SPEED_W  = 12;
    localparam int unsigned PERIOD_W = 20;
    localparam int unsigned CMD_W    = 16;
    localparam int unsigned DIR_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 20;

    // Timing constants
    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned STEPS_PER_UNIT   = 25;
    // Longest period that a nonzero speed can give (slowest rate is one unit)
    localparam int unsigned MAX_RUN_PERIOD   = TICKS_PER_SECOND / STEPS_PER_UNIT;

    // Divider sizing: quotient bits and divisor width
    localparam int unsigned DIV_STEPS = PERIOD_W;
    localparam int unsigned RATE_W    = 16;
    localparam int unsigned CNT_W     = 5;

    // Register reset values
    localparam logic [ACCEL_W-1:0]  RST_MAX_ACCEL = ACCEL_W'(8);
    localparam logic [ACCEL_W-1:0]  RST_MAX_SPEED = ACCEL_W'(500);
    localparam logic [PERIOD_W-1:0] RST_ZERO_PER  = PERIOD_W'(65535);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PER   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT = 2'd3;

    // Direction codes
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_SCALE,
        ST_DIV,
        ST_CLAMP,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/stepper_speed_ramp_step_generator.sv =====
// A tick request goes from acceptance straight to the result stage; a speed
// command goes through the ramp, scale, divide and clamp states, the divide
// being a bit-serial divider that turns the step rate into a toggle period (one
// quotient bit per cycle). A command that leaves the speed at zero skips the
// divide and clamp states.
// One request at a time: the next is accepted the cycle after the result is
// loaded, and later while a result waits in the output register.
// Reset: synchronous, active low; clears the motion state and the result
// valid, and loads the register defaults.
`default_nettype none

module stepper_speed_ramp_step_generator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Configuration write port
    input  wire logic                                  i_cfg_we,
    input  wire logic [ssr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  wire logic [ssr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // Request channel
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_kind,
    input  wire logic signed [ssr_pkg::CMD_W-1:0]      i_command,
    // Result channel
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic signed [ssr_pkg::SPEED_W-1:0]         o_applied_speed,
    output logic [ssr_pkg::DIR_W-1:0]                  o_direction,
    output logic                                       o_dir_pin,
    output logic                                       o_step_pin,
    output logic [ssr_pkg::PERIOD_W-1:0]               o_step_period
);
    import ssr_pkg::*;

    // Configuration registers
    logic [ACCEL_W-1:0]  r_max_accel;
    logic [ACCEL_W-1:0]  r_max_speed;
    logic [PERIOD_W-1:0] r_zero_per;
    logic                r_dir_invert;

    // Control state
    t_state              r_state, n_state;
    logic signed [SPEED_W-1:0] r_speed;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_tick_cnt;
    logic                r_step_level;
    logic                r_running;
    logic                r_dir_level;
    logic                r_out_valid;

    // Work registers
    logic signed [CMD_W-1:0] r_cmd;
    logic [RATE_W-1:0]   r_div;
    logic [RATE_W-1:0]   r_rem;
    logic [PERIOD_W-1:0] r_quo;
    logic [CNT_W-1:0]    r_cnt;

    // Output payload
    logic signed [SPEED_W-1:0] r_out_speed;
    logic [DIR_W-1:0]    r_out_dir;
    logic                r_out_dir_pin;
    logic                r_out_step_pin;
    logic [PERIOD_W-1:0] r_out_period;

    // Sequencer controls
    logic w_accept;
    logic w_load_out;
    logic w_div_last;

    // Datapath nets
    logic signed [CMD_W:0]   w_neg_cmd;
    logic signed [CMD_W:0]   w_lim;
    logic signed [CMD_W:0]   w_target_c;
    logic signed [SPEED_W:0] w_target;
    logic signed [SPEED_W+1:0] w_diff;
    logic signed [SPEED_W+1:0] w_acc;
    logic signed [SPEED_W+1:0] w_new_speed;
    logic [ACCEL_W-1:0]  w_mag;
    logic [RATE_W-1:0]   w_rate;
    logic [RATE_W:0]     w_rem_sh;
    logic [RATE_W+1:0]   w_sub;
    logic                w_ge;
    logic [PERIOD_W-1:0] w_tick_next;
    logic [PERIOD_W-1:0] w_per_clamped;
    logic [DIR_W-1:0]    w_dir;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_kind ? ST_DONE : ST_RAMP;
                end
            end
            ST_RAMP:  n_state = ST_SCALE;
            ST_SCALE: n_state = (r_speed == '0) ? ST_DONE : ST_DIV;
            ST_DIV:   n_state = w_div_last ? ST_CLAMP : ST_DIV;
            ST_CLAMP: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        w_accept   = (r_state == ST_IDLE) && i_valid;
        w_load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);
        w_div_last = (r_state == ST_DIV) && (r_cnt == CNT_W'(DIV_STEPS - 1));
    end

    // Clamp the negated command and ramp toward it
    always_comb begin
        w_neg_cmd = -(CMD_W+1)'(r_cmd);
        w_lim     = $signed({{(CMD_W+1-ACCEL_W){1'b0}}, r_max_speed});
        if (w_neg_cmd > w_lim) begin
            w_target_c = w_lim;
        end else if (w_neg_cmd < -w_lim) begin
            w_target_c = -w_lim;
        end else begin
            w_target_c = w_neg_cmd;
        end
        w_target = w_target_c[SPEED_W:0];
        w_acc    = $signed({{(SPEED_W+2-ACCEL_W){1'b0}}, r_max_accel});
        w_diff   = (SPEED_W+2)'(r_speed) - (SPEED_W+2)'(w_target);
        if (w_diff > w_acc) begin
            w_new_speed = (SPEED_W+2)'(r_speed) - w_acc;
        end else if (w_diff < -w_acc) begin
            w_new_speed = (SPEED_W+2)'(r_speed) + w_acc;
        end else begin
            w_new_speed = (SPEED_W+2)'(w_target);
        end
    end

    // Step rate: magnitude times 25 as shifts and adds
    always_comb begin
        logic [SPEED_W-1:0] abs_speed;
        abs_speed = r_speed[SPEED_W-1] ? SPEED_W'(-r_speed) : SPEED_W'(r_speed);
        w_mag  = abs_speed[ACCEL_W-1:0];
        w_rate = (RATE_W'(w_mag) << 4) + (RATE_W'(w_mag) << 3) + RATE_W'(w_mag);
    end

    // One restoring divide step
    always_comb begin
        w_rem_sh = {r_rem, r_quo[PERIOD_W-1]};
        w_sub    = {1'b0, w_rem_sh} - {2'b00, r_div};
        w_ge     = !w_sub[RATE_W+1];
    end

    // Period clamp, tick advance and direction code
    always_comb begin
        w_per_clamped = (r_quo > r_zero_per) ? r_zero_per : r_quo;
        w_tick_next   = r_tick_cnt + PERIOD_W'(1);
        if (r_speed > 0) begin
            w_dir = DIR_FWD;
        end else if (r_speed < 0) begin
            w_dir = DIR_REV;
        end else begin
            w_dir = DIR_STOP;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_accel  <= RST_MAX_ACCEL;
            r_max_speed  <= RST_MAX_SPEED;
            r_zero_per   <= RST_ZERO_PER;
            r_dir_invert <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ACCEL:  r_max_accel  <= i_cfg_data[ACCEL_W-1:0];
                CFG_MAX_SPEED:  r_max_speed  <= i_cfg_data[ACCEL_W-1:0];
                CFG_ZERO_PER:   r_zero_per   <= i_cfg_data[PERIOD_W-1:0];
                CFG_DIR_INVERT: r_dir_invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Control state and motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_speed      <= '0;
            r_period     <= RST_ZERO_PER;
            r_tick_cnt   <= '0;
            r_step_level <= 1'b0;
            r_running    <= 1'b0;
            r_dir_level  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Advance the step generator on a tick request
            if (w_accept && i_kind && r_running) begin
                if (w_tick_next >= r_period) begin
                    r_step_level <= ~r_step_level;
                    r_tick_cnt   <= '0;
                end else begin
                    r_tick_cnt   <= w_tick_next;
                end
            end

            // Ramp the applied speed
            if (r_state == ST_RAMP) begin
                r_speed <= w_new_speed[SPEED_W-1:0];
            end

            // Stop the generator at zero speed
            if (r_state == ST_SCALE && r_speed == '0) begin
                r_period  <= r_zero_per;
                r_running <= 1'b0;
            end

            // Take the new period and direction
            if (r_state == ST_CLAMP) begin
                r_period    <= w_per_clamped;
                r_running   <= 1'b1;
                r_dir_level <= (r_speed > 0) ^ r_dir_invert;
            end

            // Hold the result until it is taken
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command latch and divider
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_command;
        end
        if (r_state == ST_SCALE) begin
            r_div <= w_rate;
            r_rem <= '0;
            r_quo <= PERIOD_W'(TICKS_PER_SECOND);
            r_cnt <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem <= w_ge ? w_sub[RATE_W-1:0] : w_rem_sh[RATE_W-1:0];
            r_quo <= {r_quo[PERIOD_W-2:0], w_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_speed    <= r_speed;
            r_out_dir      <= w_dir;
            r_out_dir_pin  <= r_dir_level;
            r_out_step_pin <= r_step_level;
            r_out_period   <= r_period;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_applied_speed = r_out_speed;
    assign o_direction     = r_out_dir;
    assign o_dir_pin       = r_out_dir_pin;
    assign o_step_pin      = r_out_step_pin;
    assign o_step_period   = r_out_period;

endmodule

`default_nettype wire

// ===== hw/rtl/ssr_checker.sv =====
`default_nettype none

module ssr_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic                                  o_ready,
    input  wire logic                                  o_valid,
    input  wire logic                                  i_ready,
    input  wire logic signed [ssr_pkg::SPEED_W-1:0]    o_applied_speed,
    input  wire logic [ssr_pkg::DIR_W-1:0]             o_direction,
    input  wire logic                                  o_step_pin,
    input  wire logic [ssr_pkg::PERIOD_W-1:0]          o_step_period
);
    import ssr_pkg::*;

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_applied_speed)
            && $stable(o_step_period) && $stable(o_step_pin))
        else $error("result changed while stalled");

    // Direction code follows the sign of the applied speed
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_direction == DIR_STOP) == (o_applied_speed == '0))
            && ((o_direction == DIR_FWD) == (o_applied_speed > 0)))
        else $error("direction code disagrees with speed sign");

    // A running motor never has a period beyond the slowest step rate
    a_run_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_direction != DIR_STOP)
            |-> o_step_period <= PERIOD_W'(MAX_RUN_PERIOD))
        else $error("running period out of range");

    // No new request is taken in the cycle after one is accepted
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted while busy");

endmodule

bind stepper_speed_ramp_step_generator ssr_checker u_ssr_checker (.*);

`default_nettype wire
